### rtl/pwm_meter_pkg.sv
// Shared types and constants of the PWM period, width and duty meter.
`default_nettype none
package pwm_meter_pkg;

  // Field widths.
  localparam int unsigned CAP_BITS  = 16;
  localparam int unsigned PER_BITS  = CAP_BITS + 1;
  localparam int unsigned FREQ_BITS = 28;
  localparam int unsigned PCT_BITS  = 7;
  localparam int unsigned ADDR_BITS = 4;
  localparam int unsigned DATA_BITS = 32;

  // Shared divider: dividend width sets the number of steps.
  localparam int unsigned DIV_STEPS = FREQ_BITS;
  localparam int unsigned CNT_BITS  = $clog2(DIV_STEPS);

  // Duty scale and saturation point.
  localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TIMER_TOP = 2'd0;
  localparam logic [1:0] REG_CLOCK_HZ  = 2'd1;
  localparam logic [1:0] REG_PRESCALER = 2'd2;

  // Register values after reset.
  localparam logic [CAP_BITS-1:0]  TIMER_TOP_RST = 16'hFFFF;
  localparam logic [FREQ_BITS-1:0] CLOCK_HZ_RST  = 28'd84000000;
  localparam logic [CAP_BITS-1:0]  PRESCALER_RST = 16'd83;

  // One measurement request.
  typedef struct packed {
    logic [0:0]          channel;
    logic                period_ready;
    logic                width_ready;
    logic [CAP_BITS-1:0] rise_first;
    logic [CAP_BITS-1:0] rise_second;
    logic [CAP_BITS-1:0] fall_first;
    logic [CAP_BITS-1:0] fall_second;
  } req_t;

  // One measurement result.
  typedef struct packed {
    logic [PER_BITS-1:0]  period_ticks;
    logic [FREQ_BITS-1:0] frequency_hz;
    logic [CAP_BITS-1:0]  pulse_width_ticks;
    logic [PCT_BITS-1:0]  duty_percent;
    logic                 width_found;
    logic                 period_zero;
  } rsp_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PERIOD = 5'b00010,
    ST_WIDTH  = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  // Which quotient the shared divider is producing.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_FREQ = 2'd1,
    OP_DUTY = 2'd2
  } div_op_t;

endpackage
`default_nettype wire

### rtl/pwm_period_width_duty_meter.sv
// Top level of the PWM period, width and duty meter with its shared divider.
// Each request names a channel and carries two rising and two falling timer
// captures; the block updates that channel's stored period, frequency, pulse
// width and duty and returns one result holding the channel's stored values.
// One shared 28-step restoring divider does all divisions: tick rate (clock
// over prescaler plus one), frequency (tick rate over period) and duty (width
// times 100 over period). A request passes through the sequencing states and
// one divider pass for each division, of which there are up to three when
// both the period and the width are updated with a nonzero period. The block
// takes one request at a time; req_ready is high only while it is idle.
// Configuration registers sit at byte addresses 0 (timer top), 4 (timer clock
// in hertz) and 8 (prescaler) and should be written only while idle.
`default_nettype none
module pwm_period_width_duty_meter #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Request channel
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  pwm_meter_pkg::req_t                  req,
  // Result channel
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output pwm_meter_pkg::rsp_t                  rsp,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pwm_meter_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [pwm_meter_pkg::DATA_BITS-1:0]  pwdata,
  output logic [pwm_meter_pkg::DATA_BITS-1:0]  prdata,
  output logic                                 pready
);
  import pwm_meter_pkg::*;

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic [CAP_BITS-1:0]  timer_top;
  logic [FREQ_BITS-1:0] clock_hz;
  logic [CAP_BITS-1:0]  prescaler;

  // Per-channel stored measurements.
  logic [PER_BITS-1:0]  stored_period    [CHANNELS];
  logic [FREQ_BITS-1:0] stored_frequency [CHANNELS];
  logic [CAP_BITS-1:0]  stored_width     [CHANNELS];
  logic [PCT_BITS-1:0]  stored_duty      [CHANNELS];

  // Sequencer and held request.
  state_t           state;
  div_op_t          op;
  req_t             req_q;
  logic [CH_W-1:0]  ch;
  logic             found;

  // Shared divider registers.
  logic [FREQ_BITS-1:0] div_num;
  logic [PER_BITS-1:0]  div_den;
  logic [PER_BITS-1:0]  div_rem;
  logic [CNT_BITS-1:0]  div_cnt;

  // Combinational helpers.
  logic [CH_W-1:0]      ch_in;
  logic [PER_BITS-1:0]  per_calc;
  logic [PER_BITS-1:0]  per_cur;
  logic [PER_BITS:0]    trial;
  logic                 trial_ge;
  logic [PER_BITS-1:0]  rem_step;
  logic [FREQ_BITS-1:0] q_last;
  logic                 div_last;
  logic                 win_first;
  logic                 win_second;
  logic [CAP_BITS-1:0]  width_new;
  logic [FREQ_BITS-1:0] width_scaled;
  logic                 cfg_write;

  // Channel index, saturated to the last channel.
  assign ch_in = (32'(req.channel) >= CHANNELS) ? CH_W'(CHANNELS - 1) : CH_W'(req.channel);

  // Period from the rising captures, wrapping once on the timer top.
  always_comb begin
    if (req_q.rise_first > req_q.rise_second) begin
      per_calc = {1'b0, timer_top} + PER_BITS'(1) + {1'b0, req_q.rise_second}
                 - {1'b0, req_q.rise_first};
    end else begin
      per_calc = {1'b0, req_q.rise_second} - {1'b0, req_q.rise_first};
    end
  end

  assign per_cur = stored_period[ch];

  // One restoring divider step: shift in the next dividend bit and subtract.
  assign trial    = {div_rem, div_num[FREQ_BITS-1]};
  assign trial_ge = trial >= {1'b0, div_den};
  assign rem_step = trial_ge ? PER_BITS'(trial - {1'b0, div_den}) : trial[PER_BITS-1:0];
  assign q_last   = {div_num[FREQ_BITS-2:0], trial_ge};
  assign div_last = div_cnt == CNT_BITS'(DIV_STEPS - 1);

  // Falling-capture window test and the resulting width.
  assign win_first  = (req_q.fall_first >= req_q.rise_first) &&
                      (req_q.fall_first <= req_q.rise_second);
  assign win_second = (req_q.fall_second >= req_q.rise_first) &&
                      (req_q.fall_second <= req_q.rise_second);

  always_comb begin
    priority if (win_first) begin
      width_new = req_q.fall_first - req_q.rise_first;
    end else if (win_second) begin
      width_new = req_q.fall_second - req_q.rise_first;
    end else begin
      width_new = stored_width[ch];
    end
  end

  assign width_scaled = FREQ_BITS'(width_new) * FREQ_BITS'(PCT_FULL);

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_TIMER_TOP: prdata = DATA_BITS'(timer_top);
      REG_CLOCK_HZ:  prdata = DATA_BITS'(clock_hz);
      REG_PRESCALER: prdata = DATA_BITS'(prescaler);
      default:       prdata = '0;
    endcase
  end

  // Handshake and result payload.
  assign req_ready = state == ST_IDLE;
  assign rsp_valid = state == ST_OUT;

  always_comb begin
    rsp.period_ticks      = stored_period[ch];
    rsp.frequency_hz      = stored_frequency[ch];
    rsp.pulse_width_ticks = stored_width[ch];
    rsp.duty_percent      = stored_duty[ch];
    rsp.width_found       = found;
    rsp.period_zero       = stored_period[ch] == '0;
  end

  // Sequencer, divider and stored state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      timer_top <= TIMER_TOP_RST;
      clock_hz  <= CLOCK_HZ_RST;
      prescaler <= PRESCALER_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        stored_period[i]    <= '0;
        stored_frequency[i] <= '0;
        stored_width[i]     <= '0;
        stored_duty[i]      <= '0;
      end
    end else begin
      // Register writes.
      if (cfg_write) begin
        unique case (paddr[3:2])
          REG_TIMER_TOP: timer_top <= pwdata[CAP_BITS-1:0];
          REG_CLOCK_HZ:  clock_hz  <= pwdata[FREQ_BITS-1:0];
          REG_PRESCALER: prescaler <= pwdata[CAP_BITS-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            ch    <= ch_in;
            found <= 1'b0;
            state <= ST_PERIOD;
          end
        end

        // Period update; start the tick-rate division if the period is nonzero.
        ST_PERIOD: begin
          if (req_q.period_ready) begin
            stored_period[ch] <= per_calc;
            if (per_calc == '0) begin
              stored_frequency[ch] <= '0;
              state <= req_q.width_ready ? ST_WIDTH : ST_OUT;
            end else begin
              op      <= OP_TICK;
              div_num <= clock_hz;
              div_den <= {1'b0, prescaler} + PER_BITS'(1);
              div_rem <= '0;
              div_cnt <= '0;
              state   <= ST_DIV;
            end
          end else begin
            state <= req_q.width_ready ? ST_WIDTH : ST_OUT;
          end
        end

        // Width update; start the duty division if the period is nonzero.
        ST_WIDTH: begin
          stored_width[ch] <= width_new;
          found            <= win_first || win_second;
          if (per_cur == '0) begin
            stored_duty[ch] <= '0;
            state <= ST_OUT;
          end else begin
            op      <= OP_DUTY;
            div_num <= width_scaled;
            div_den <= per_cur;
            div_rem <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end
        end

        // Shared divider, one quotient bit per cycle.
        ST_DIV: begin
          if (!div_last) begin
            div_num <= q_last;
            div_rem <= rem_step;
            div_cnt <= div_cnt + CNT_BITS'(1);
          end else begin
            unique case (op)
              OP_TICK: begin
                op      <= OP_FREQ;
                div_num <= q_last;
                div_den <= per_cur;
                div_rem <= '0;
                div_cnt <= '0;
              end
              OP_FREQ: begin
                stored_frequency[ch] <= q_last;
                state <= req_q.width_ready ? ST_WIDTH : ST_OUT;
              end
              OP_DUTY: begin
                stored_duty[ch] <= (q_last > FREQ_BITS'(PCT_FULL)) ? PCT_FULL
                                                                  : q_last[PCT_BITS-1:0];
                state <= ST_OUT;
              end
              default: state <= ST_OUT;
            endcase
          end
        end

        ST_OUT: begin
          if (rsp_ready) begin
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The block never takes a request while a result is pending.
  a_req_rsp_excl: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request accepted while a result is pending");

  // A delivered result returns the block to idle.
  a_rsp_to_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready) |=> req_ready)
    else $error("block not idle after result delivery");

  // An accepted request is never answered in the very next cycle.
  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !rsp_valid)
    else $error("result appeared without sequencing");

  // Reported duty is saturated at full scale.
  a_duty_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.duty_percent <= PCT_FULL))
    else $error("duty above full scale");

  // A zero period always reports zero frequency.
  a_zero_period: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.period_zero) |-> (rsp.frequency_hz == '0))
    else $error("nonzero frequency with zero period");
`endif

endmodule
`default_nettype wire
